/* hdl/bgd_pkg.sv */
`timescale 1ns / 1ps

package bgd_pkg;

  // Field widths fixed by the stream and register layout.
  localparam int CLICK_WINDOW_W = 8;
  localparam int LONG_LIMIT_W   = 16;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_INDEX_W    = 1;
  localparam int KIND_W         = 2;

  // Click classification codes.
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DOUBLE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_CLICK_WINDOW = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_LIMIT   = 1'd1;

  // Register reset values.
  localparam logic [CLICK_WINDOW_W-1:0] CLICK_WINDOW_RST = 8'd50;
  localparam logic [LONG_LIMIT_W-1:0]   LONG_LIMIT_RST   = 16'd200;

  // One scan tick handed to the detectors.
  typedef struct packed {
    logic step;       // tick accepted this cycle
    logic key_level;  // pin level, 0 pressed
  } tick_t;

endpackage

/* hdl/button_gesture_decoder_top.sv */
`timescale 1ns / 1ps
// A result word appears in the cycle after its input word is accepted.
// Throughput: one word per clock while downstream takes each result; the result
// register is reloaded in the same cycle that downstream takes the previous word.
// Reset (rst, synchronous): all detector state, both flags and the output
// valid clear; click_window returns to 50 and the long press limit to 200.
module button_gesture_decoder_top
  import bgd_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [0] key_level
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [7:0]             m_axis_tdata,   // [1:0] click_kind, [2] long press seen,
                                                 // [3] stop_flag, [4] show_flag
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [CLICK_WINDOW_W-1:0] click_window;
  logic [LONG_LIMIT_W-1:0]   long_limit;
  tick_t                     tick;
  logic                      accept;
  logic [KIND_W-1:0]         kind;
  logic                      long_hit;
  logic                      out_valid;
  logic [KIND_W-1:0]         out_kind;
  logic                      out_long;
  logic                      stop_state;
  logic                      show_state;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      click_window <= CLICK_WINDOW_RST;
      long_limit   <= LONG_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLICK_WINDOW: click_window <= cfg_data[CLICK_WINDOW_W-1:0];
        REG_LONG_LIMIT:   long_limit   <= cfg_data[LONG_LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Take a word whenever the result register is empty or being drained.
  assign s_axis_tready  = !out_valid || m_axis_tready;
  assign accept         = s_axis_tvalid && s_axis_tready;
  assign tick.step      = accept;
  assign tick.key_level = s_axis_tdata[0];

  bgd_click #(.COUNT_WIDTH(COUNT_WIDTH)) u_click (
    .clk          (clk),
    .rst          (rst),
    .tick         (tick),
    .click_window (click_window),
    .kind         (kind)
  );

  bgd_long #(.COUNT_WIDTH(COUNT_WIDTH)) u_long (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick),
    .long_limit (long_limit),
    .long_hit   (long_hit)
  );

  // Result register and the two flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      stop_state <= 1'b0;
      show_state <= 1'b0;
    end else begin
      if (accept) begin
        out_valid  <= 1'b1;
        stop_state <= stop_state ^ (kind == KIND_SINGLE);
        show_state <= show_state ^ long_hit;
      end else if (m_axis_tready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_kind <= kind;
      out_long <= long_hit;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, show_state, stop_state, out_long, out_kind};

  // Every accepted word yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid)
    else $error("accepted word produced no result");

  // A stalled result blocks the input side.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted over a stalled result");

  // The stop flag moves exactly on a single click.
  a_stop_toggle: assert property (@(posedge clk) disable iff (rst)
    accept |=> ((stop_state != $past(stop_state)) == ($past(kind) == KIND_SINGLE)))
    else $error("stop flag out of step with single click");

  // The show flag moves exactly on a long press report.
  a_show_toggle: assert property (@(posedge clk) disable iff (rst)
    accept |=> ((show_state != $past(show_state)) == $past(long_hit)))
    else $error("show flag out of step with long press");

  // Flags hold when no word is accepted.
  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(stop_state) && $stable(show_state))
    else $error("flag changed without an accepted word");

endmodule

/* hdl/bgd_click.sv */
`timescale 1ns / 1ps

module bgd_click
  import bgd_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  tick_t                     tick,
  input  logic [CLICK_WINDOW_W-1:0] click_window,
  output logic [KIND_W-1:0]         kind
);

  logic                   press_seen;
  logic                   press_counted;
  logic [1:0]             press_tally;
  logic [COUNT_WIDTH-1:0] window_count;
  logic [COUNT_WIDTH-1:0] hold_count;

  logic                   press_seen_next;
  logic                   press_counted_next;
  logic [1:0]             press_tally_next;
  logic [COUNT_WIDTH-1:0] window_count_next;
  logic [COUNT_WIDTH-1:0] hold_count_next;

  logic                   seen_a;
  logic                   counted_a;
  logic [1:0]             tally_a;
  logic                   double_hit;
  logic [COUNT_WIDTH-1:0] window_inc;
  logic [COUNT_WIDTH-1:0] window_limit;

  assign window_limit = COUNT_WIDTH'(click_window);
  assign window_inc   = (window_count == '1) ? window_count : window_count + 1'b1;

  // Classify the tick and work out the next counter state.
  always_comb begin
    hold_count_next = tick.key_level ? '0 :
                      ((hold_count == '1) ? hold_count : hold_count + 1'b1);
    seen_a     = press_seen | ~tick.key_level;
    tally_a    = press_tally;
    counted_a  = press_counted;
    double_hit = 1'b0;

    // Count a new press once, then check for the second press.
    if (!press_counted) begin
      if (seen_a) begin
        tally_a   = (press_tally == 2'd3) ? press_tally : press_tally + 2'd1;
        counted_a = 1'b1;
      end
      double_hit = (tally_a == 2'd2);
    end

    press_seen_next    = seen_a;
    press_counted_next = counted_a;
    press_tally_next   = tally_a;
    window_count_next  = window_count;
    kind               = KIND_NONE;

    if (double_hit) begin
      press_tally_next  = 2'd0;
      window_count_next = '0;
      kind              = KIND_DOUBLE;
    end else begin
      // A release rearms the press edge.
      if (tick.key_level) begin
        press_seen_next    = 1'b0;
        press_counted_next = 1'b0;
      end
      // One press pending: run the window and decide on a single click.
      if (tally_a == 2'd1) begin
        if (window_inc > window_limit && hold_count_next < window_limit) begin
          press_tally_next  = 2'd0;
          window_count_next = '0;
          kind              = KIND_SINGLE;
        end else if (hold_count_next > window_limit) begin
          press_tally_next  = 2'd0;
          window_count_next = '0;
        end else begin
          window_count_next = window_inc;
        end
      end
    end
  end

  // State update on each accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      press_seen    <= 1'b0;
      press_counted <= 1'b0;
      press_tally   <= 2'd0;
      window_count  <= '0;
      hold_count    <= '0;
    end else if (tick.step) begin
      press_seen    <= press_seen_next;
      press_counted <= press_counted_next;
      press_tally   <= press_tally_next;
      window_count  <= window_count_next;
      hold_count    <= hold_count_next;
    end
  end

endmodule

/* hdl/bgd_long.sv */
`timescale 1ns / 1ps

module bgd_long
  import bgd_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  tick_t                   tick,
  input  logic [LONG_LIMIT_W-1:0] long_limit,
  output logic                    long_hit
);

  localparam int CMP_W = (COUNT_WIDTH > LONG_LIMIT_W) ? COUNT_WIDTH : LONG_LIMIT_W;

  logic                   long_latch;
  logic [COUNT_WIDTH-1:0] long_count;
  logic [COUNT_WIDTH-1:0] long_count_a;
  logic [CMP_W-1:0]       count_ext;
  logic [CMP_W-1:0]       limit_ext;

  // Held ticks count up while not paused by the latch.
  assign long_count_a = (!long_latch && !tick.key_level) ?
                        ((long_count == '1) ? long_count : long_count + 1'b1) : '0;
  assign count_ext    = CMP_W'(long_count_a);
  assign limit_ext    = CMP_W'(long_limit);
  assign long_hit     = (count_ext > limit_ext);

  // A report restarts the count and pauses it for one tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      long_latch <= 1'b0;
      long_count <= '0;
    end else if (tick.step) begin
      long_latch <= long_hit;
      long_count <= long_hit ? '0 : long_count_a;
    end
  end

endmodule

/* test/bgd_result_checker.sv */
`timescale 1ns / 1ps

module bgd_result_checker
  import bgd_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [0] key_level
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [7:0]             m_axis_tdata,   // [1:0] click_kind, [2] long press seen,
                                                 // [3] stop_flag, [4] show_flag
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     outstanding
);

  // One result word, laid out as on m_axis_tdata.
  typedef struct packed {
    logic              show;
    logic              stop;
    logic              long_rpt;
    logic [KIND_W-1:0] kind;
  } gesture_word_t;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Local copy of the registers and the detector state.
  logic [CLICK_WINDOW_W-1:0] window_limit;
  logic [LONG_LIMIT_W-1:0]   long_limit;
  logic                      press_seen;
  logic                      press_counted;
  logic [1:0]                press_tally;
  logic [COUNT_WIDTH-1:0]    window_count;
  logic [COUNT_WIDTH-1:0]    hold_count;
  logic [COUNT_WIDTH-1:0]    long_count;
  logic                      long_latch;
  logic                      stop_state;
  logic                      show_state;

  gesture_word_t expected_words[$];
  int            words_seen;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    words_seen  = 0;
  end

  // Counters stick at all ones instead of wrapping.
  function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] value);
    return (value == COUNT_MAX) ? value : value + 1'b1;
  endfunction

  // Advance the detector by one scan tick and return the word it reports.
  function automatic gesture_word_t predict_tick(input logic key);
    gesture_word_t word;
    logic          long_hit;
    word.kind = KIND_NONE;

    // Click classification: press edge, tally, click window and hold time.
    if (!key) begin
      hold_count = bump(hold_count);
      press_seen = 1'b1;
    end else begin
      hold_count = '0;
    end
    if (!press_counted) begin
      if (press_seen) begin
        if (press_tally != 2'd3) begin
          press_tally = press_tally + 1'b1;
        end
        press_counted = 1'b1;
      end
      if (press_tally == 2'd2) begin
        press_tally  = '0;
        window_count = '0;
        word.kind    = KIND_DOUBLE;
      end
    end
    // A double click ends the tick early; the release does not clear the edge state then.
    if (word.kind != KIND_DOUBLE) begin
      if (key) begin
        press_seen    = 1'b0;
        press_counted = 1'b0;
      end
      if (press_tally == 2'd1) begin
        window_count = bump(window_count);
        if (window_count > window_limit && hold_count < window_limit) begin
          press_tally  = '0;
          window_count = '0;
          word.kind    = KIND_SINGLE;
        end else if (hold_count > window_limit) begin
          // Held too long: the pending press is dropped silently.
          press_tally  = '0;
          window_count = '0;
        end
      end
    end
    if (word.kind == KIND_SINGLE) begin
      stop_state = ~stop_state;
    end

    // Long press: the tick after a report holds the counter at zero.
    if (!long_latch && !key) begin
      long_count = bump(long_count);
    end else begin
      long_count = '0;
    end
    long_hit = (long_count > long_limit);
    if (long_hit) begin
      long_count = '0;
      show_state = ~show_state;
    end
    long_latch = long_hit;

    word.long_rpt = long_hit;
    word.stop     = stop_state;
    word.show     = show_state;
    return word;
  endfunction

  // Follow both channels and the register port at every rising edge.
  always @(posedge clk) begin
    gesture_word_t seen;
    gesture_word_t want;
    if (rst) begin
      window_limit  = CLICK_WINDOW_RST;
      long_limit    = LONG_LIMIT_RST;
      press_seen    = 1'b0;
      press_counted = 1'b0;
      press_tally   = '0;
      window_count  = '0;
      hold_count    = '0;
      long_count    = '0;
      long_latch    = 1'b0;
      stop_state    = 1'b0;
      show_state    = 1'b0;
      expected_words.delete();
    end else begin
      // Compare each accepted result word with the oldest prediction.
      if (m_axis_tvalid && m_axis_tready) begin
        seen = m_axis_tdata[$bits(gesture_word_t)-1:0];
        if (expected_words.size() == 0) begin
          if (mismatches < 10) begin
            $display("result word %0d arrived with no prediction pending: tdata=%h",
                     words_seen, m_axis_tdata);
          end
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (seen.kind !== want.kind || seen.long_rpt !== want.long_rpt ||
              seen.stop !== want.stop || seen.show !== want.show) begin
            if (mismatches < 10) begin
              $display({"result word %0d: expected kind=%0d long=%0d stop=%0d show=%0d,",
                        " got kind=%0d long=%0d stop=%0d show=%0d"},
                       words_seen, want.kind, want.long_rpt, want.stop, want.show,
                       seen.kind, seen.long_rpt, seen.stop, seen.show);
            end
            mismatches++;
          end
        end
        words_seen++;
      end

      // Register writes are for idle only; the user must keep to it, the checker does not enforce it.
      if (cfg_we) begin
        case (cfg_index)
          REG_CLICK_WINDOW: begin
            window_limit = cfg_data[CLICK_WINDOW_W-1:0];
          end
          REG_LONG_LIMIT: begin
            long_limit = cfg_data[LONG_LIMIT_W-1:0];
          end
          default: begin
          end
        endcase
      end

      // Every accepted tick yields exactly one result word.
      if (s_axis_tvalid && s_axis_tready) begin
        expected_words.push_back(predict_tick(s_axis_tdata[0]));
      end
    end
    outstanding <= expected_words.size();
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
  import bgd_pkg::*;

  localparam int COUNT_WIDTH = 16;
  localparam int PHASE_TICKS = 150;

  // Directed ticks, tick 0 in bit 0: double click, single click, over-long hold with
  // two long press reports, then release. Run with a click window of 2 and a limit of 3.
  localparam logic [24:0] DIRECTED_KEYS = 25'b111_000000000_11111_0_1111_0_1_0;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata  = 8'hFF;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [7:0]             m_axis_tdata;
  logic                   cfg_we        = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index     = REG_CLICK_WINDOW;
  logic [CFG_DATA_W-1:0]  cfg_data      = '0;

  int mismatches;
  int outstanding;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  always #2 clk = ~clk;

  button_gesture_decoder_top #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  bgd_result_checker #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // Downstream stalls at random according to the current idle rate.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offer one scan tick, with random gaps ahead of it, and wait until it is taken.
  task automatic send_tick(input logic key);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, key};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stop sending and wait until every predicted word has come back.
  task automatic drain_results;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write both registers on back-to-back cycles.
  task automatic set_config(input logic [CLICK_WINDOW_W-1:0] window,
                            input logic [LONG_LIMIT_W-1:0]   limit);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CLICK_WINDOW;
    cfg_data  <= CFG_DATA_W'(window);
    @(posedge clk);
    cfg_index <= REG_LONG_LIMIT;
    cfg_data  <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One press followed by a release, with lengths placed around the click window
  // and the long press limit; now and then a burst of random levels instead.
  task automatic send_gesture(input int unsigned window, input int unsigned limit,
                              output int unsigned sent);
    int unsigned press_len;
    int unsigned gap_len;
    if ($urandom_range(9) == 0) begin
      sent = $urandom_range(1, 8);
      repeat (sent) send_tick(1'($urandom_range(1)));
    end else begin
      case ($urandom_range(3))
        0: press_len = $urandom_range(1, 3);
        1: begin
          press_len = window + $urandom_range(0, 2);
          if (press_len > 1) press_len--;
        end
        2: press_len = (limit < 300) ? limit + $urandom_range(1, 3) : $urandom_range(1, 3);
        default: press_len = (limit < 100) ? 2 * limit + $urandom_range(2, 6)
                                           : $urandom_range(1, 6);
      endcase
      case ($urandom_range(3))
        0: gap_len = $urandom_range(1, 2);
        1: gap_len = window + $urandom_range(0, 2);
        2: gap_len = window + $urandom_range(3, 6);
        default: gap_len = $urandom_range(1, window + 3);
      endcase
      if (gap_len == 0) gap_len = 1;
      repeat (press_len) send_tick(1'b0);
      repeat (gap_len) send_tick(1'b1);
      sent = press_len + gap_len;
    end
  endtask

  // Stimulus: directed ticks, random gesture phases, then a long hold at the top limit.
  initial begin
    int unsigned window;
    int unsigned limit;
    int unsigned ticks;
    int unsigned sent;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_config(8'd2, 16'd3);
    send_idle_pct = 27;
    recv_idle_pct = 50;
    for (int i = 0; i < 25; i++) begin
      send_tick(DIRECTED_KEYS[i]);
    end

    for (int phase = 0; phase < 6; phase++) begin
      drain_results();
      case (phase / 2)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 50;
        end
        1: begin
          send_idle_pct = 50;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (phase)
        0: begin
          window = 4;
          limit  = 6;
        end
        1: begin
          window = $urandom_range(0, 12);
          limit  = $urandom_range(0, 24);
        end
        2: begin
          window = 255;
          limit  = 0;
        end
        3: begin
          window = 0;
          limit  = $urandom_range(1, 8);
        end
        4: begin
          window = $urandom_range(1, 12);
          limit  = $urandom_range(0, 30);
        end
        default: begin
          window = CLICK_WINDOW_RST;
          limit  = LONG_LIMIT_RST;
        end
      endcase
      set_config(window[CLICK_WINDOW_W-1:0], limit[LONG_LIMIT_W-1:0]);
      ticks = 0;
      while (ticks < PHASE_TICKS) begin
        send_gesture(window, limit, sent);
        ticks += sent;
        if ($urandom_range(49) == 0) drain_results();
      end
    end

    // Limit at its maximum: a hold well past the click window reports nothing.
    drain_results();
    set_config(8'd255, 16'hFFFF);
    repeat (300) send_tick(1'b0);
    repeat (60) send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("button_gesture_decoder_top: match");
    end else begin
      $display("button_gesture_decoder_top: mismatch");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("button_gesture_decoder_top: mismatch");
    $finish;
  end

endmodule
